FILE: hw/rtl/inverse_normal_cdf_rational_core_macros.svh
// Assertion macros for the inverse normal CDF core.
// Used by inverse_normal_cdf_rational_core.sv; no other dependencies.
`ifndef INVERSE_NORMAL_CDF_RATIONAL_CORE_MACROS_SVH
`define INVERSE_NORMAL_CDF_RATIONAL_CORE_MACROS_SVH

// Property that must hold at every edge outside reset.
`define INCDF_ASSERT(label, prop, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// Implication checked on the next cycle.
`define INCDF_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: hw/rtl/incdf_pkg.sv
// Shared types and constants for the inverse normal CDF core.
// Q32 coefficient tables, split multiplier helpers and stage payload types; no dependencies.
package incdf_pkg;

    localparam int PROB_BITS_DEF = 32;
    localparam int FRAC_BITS_DEF = 24;

    typedef logic signed [63:0] q32_t;

    // Partial products of one Q32 multiply: sign and four 32x32 products
    typedef struct packed {
        logic        neg;
        logic [63:0] p3;    // a_hi * b_hi
        logic [63:0] p2;    // a_hi * b_lo
        logic [63:0] p1;    // a_lo * b_hi
        logic [63:0] p0;    // a_lo * b_lo
    } mpart_t;

    // Region codes
    localparam logic [1:0] REG_CENTER = 2'd0;
    localparam logic [1:0] REG_LOWER  = 2'd1;
    localparam logic [1:0] REG_UPPER  = 2'd2;
    localparam logic [1:0] REG_ZERO   = 2'd3;

    // Coefficients, published values rounded to 9 decimals then to Q32.
    function automatic q32_t fxp(input longint i, input longint f);
        longint fr;
        fr = ((f <<< 32) + 64'sd500000000) / 64'sd1000000000;
        return q32_t'((i <<< 32) + fr);
    endfunction

    function automatic q32_t coef_a(input int k);
        q32_t v;
        case (k)
            0: v = -fxp(39, 696830287);
            1: v =  fxp(220, 946098425);
            2: v = -fxp(275, 928510447);
            3: v =  fxp(138, 357751867);
            4: v = -fxp(30, 664798066);
            default: v = fxp(2, 506628277);
        endcase
        return v;
    endfunction

    function automatic q32_t coef_b(input int k);
        q32_t v;
        case (k)
            0: v = -fxp(54, 476098798);
            1: v =  fxp(161, 585836858);
            2: v = -fxp(155, 698979860);
            3: v =  fxp(66, 801311888);
            default: v = -fxp(13, 280681553);
        endcase
        return v;
    endfunction

    function automatic q32_t coef_c(input int k);
        q32_t v;
        case (k)
            0: v = -fxp(0, 7784894);
            1: v = -fxp(0, 322396458);
            2: v = -fxp(2, 400758277);
            3: v = -fxp(2, 549732539);
            4: v =  fxp(4, 374664141);
            default: v = fxp(2, 938163983);
        endcase
        return v;
    endfunction

    function automatic q32_t coef_d(input int k);
        q32_t v;
        case (k)
            0: v = fxp(0, 7784696);
            1: v = fxp(0, 322467129);
            2: v = fxp(2, 445134137);
            default: v = fxp(3, 754408662);
        endcase
        return v;
    endfunction

    // 2 ln 2 = 1.386294361 in Q32
    localparam q32_t TWO_LN2 = q32_t'(64'sd5954088943);

    // First half of a Q32 product: magnitudes and four 32x32 partial products.
    function automatic mpart_t mul_parts(input q32_t a, input q32_t b);
        logic [63:0] ma;
        logic [63:0] mb;
        mpart_t      r;
        ma    = a[63] ? 64'(-a) : 64'(a);
        mb    = b[63] ? 64'(-b) : 64'(b);
        r.neg = a[63] ^ b[63];
        r.p0  = {32'd0, ma[31:0]} * {32'd0, mb[31:0]};
        r.p1  = {32'd0, ma[31:0]} * {32'd0, mb[63:32]};
        r.p2  = {32'd0, ma[63:32]} * {32'd0, mb[31:0]};
        r.p3  = {32'd0, ma[63:32]} * {32'd0, mb[63:32]};
        return r;
    endfunction

    // Second half: sum, round half away from zero, saturate, apply sign.
    function automatic q32_t mul_sum(input mpart_t r);
        logic [127:0] p;
        logic [63:0]  mag;
        p = 128'(r.p0) + (128'(r.p1) << 32) + (128'(r.p2) << 32) + (128'(r.p3) << 64)
            + 128'(64'h8000_0000);
        if (p[127:95] != '0)
            mag = 64'h7FFF_FFFF_FFFF_FFFF;
        else
            mag = p[95:32];
        return r.neg ? q32_t'(-mag) : q32_t'(mag);
    endfunction

endpackage

FILE: hw/rtl/inverse_normal_cdf_rational_core.sv
// Inverse standard normal CDF core (rational approximation), top level.
// Depends on incdf_pkg and inverse_normal_cdf_rational_core_macros.svh.
//
// Usage:
//  - s_axis carries one probability code per transfer (u = code/2^PROB_BITS).
//  - m_axis returns the quantile z, signed with FRAC_BITS fraction bits.
//  - Code zero returns the most negative code; overflow saturates.
//  - Pipeline: normalize (1), log2 by 32 square steps (32), -2 ln p or r
//    as a two-stage product (2), square root by 41 shift-subtract steps
//    (41), coefficient select (1), Horner with each product split over
//    two stages (12), divide setup (1), a 64-step restoring divide, one
//    quotient bit per stage (64), then output saturation (1): NSTG = 155.
//  - Throughput: one transfer per cycle while the output is not
//    stalled, set by the fully staged datapath.
//  - Stalls: all stages advance together on a shared enable; when the output
//    holds a result that is not taken, the whole pipe freezes, so nothing
//    is lost or repeated; s_axis_tready drops only then.
//  - Reset: valid bits clear; payload registers are not reset.
`include "inverse_normal_cdf_rational_core_macros.svh"

module inverse_normal_cdf_rational_core #(
    parameter int PROB_BITS = incdf_pkg::PROB_BITS_DEF,
    parameter int FRAC_BITS = incdf_pkg::FRAC_BITS_DEF
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    input  logic [PROB_BITS-1:0] s_axis_tdata,   // [PROB_BITS-1:0] prob_code
    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    output logic [31:0]          m_axis_tdata    // [31:0] quantile
);

    localparam int LOG_STEPS = 32;
    localparam int SQ_STEPS  = 41;
    localparam int HORN      = 6;
    localparam int DIV_STEPS = 64;
    // stage 0 normalize, log steps, 2 scale, sqrt steps, 1 select,
    // 2 per horner step, 1 divide setup, div steps, 1 out
    localparam int S_LOG  = 1;
    localparam int S_SCL  = S_LOG + LOG_STEPS;
    localparam int S_SCF  = S_SCL + 1;
    localparam int S_SQ   = S_SCF + 1;
    localparam int S_SEL  = S_SQ + SQ_STEPS;
    localparam int S_H    = S_SEL + 1;
    localparam int S_PRE  = S_H + 2 * HORN;
    localparam int S_DIV  = S_PRE + 1;
    localparam int NSTG   = S_DIV + DIV_STEPS + 1;

    typedef struct packed {
        logic [1:0]          region;
        logic [63:0]         m;      // log mantissa / -2 ln p / quotient
        logic [63:0]         f;      // log bits / remainder
        logic [6:0]          k;
        incdf_pkg::q32_t     s;      // x
        incdf_pkg::q32_t     q;      // sqrt result / r
        incdf_pkg::q32_t     acc_n;
        incdf_pkg::q32_t     acc_d;
        incdf_pkg::mpart_t   pn;     // split product, numerator side
        incdf_pkg::mpart_t   pd;     // split product, denominator side
        logic [127:0]        dvd;    // sqrt remainder, then dividend
        logic [63:0]         dvs;
        logic                big;
        logic                neg;
    } stg_t;

    stg_t       st_reg  [NSTG];
    stg_t       st_next [NSTG];
    logic [NSTG-1:0] vld_reg;
    logic       adv;

    localparam logic [63:0] FULL  = 64'(1) << PROB_BITS;
    localparam logic [63:0] T_LOW = ((64'(97) << PROB_BITS) + 64'd3999) / 64'd4000;

    assign adv           = !vld_reg[NSTG-1] || m_axis_tready;
    assign s_axis_tready = adv;
    assign m_axis_tvalid = vld_reg[NSTG-1];
    assign m_axis_tdata  = st_reg[NSTG-1].m[31:0];

    always_comb
    begin
        logic [63:0]  code;
        logic [63:0]  t;
        logic [63:0]  xc;
        logic [63:0]  sq;
        logic [127:0] rem;
        logic [127:0] trial;
        incdf_pkg::q32_t l2;
        incdf_pkg::q32_t x;
        int           kk;
        code  = 64'(s_axis_tdata);
        t     = '0;
        xc    = '0;
        sq    = '0;
        rem   = '0;
        trial = '0;
        l2    = '0;
        x     = '0;
        kk    = 0;
        // normalize stage
        st_next[0] = '0;
        if (code == 0)
            st_next[0].region = incdf_pkg::REG_ZERO;
        else if (code < T_LOW)
            st_next[0].region = incdf_pkg::REG_LOWER;
        else if (FULL - code < T_LOW)
            st_next[0].region = incdf_pkg::REG_UPPER;
        else
            st_next[0].region = incdf_pkg::REG_CENTER;
        t = (st_next[0].region == incdf_pkg::REG_UPPER) ? FULL - code : code;
        for (int i = 0; i < 64; i++)
            if (t[i])
                kk = i;
        st_next[0].k = 7'(kk);
        st_next[0].m = (kk <= 31) ? (t << (31 - kk)) : (t >> (kk - 31));
        xc = code - (64'(1) << (PROB_BITS - 1));
        if (PROB_BITS <= 32)
            x = incdf_pkg::q32_t'(xc) <<< (32 - PROB_BITS);
        else
        begin
            logic [63:0] mg;
            mg = xc[63] ? 64'(-xc) : xc;
            mg = (mg + (64'(1) << (PROB_BITS - 33))) >> (PROB_BITS - 32);
            x  = xc[63] ? incdf_pkg::q32_t'(-mg) : incdf_pkg::q32_t'(mg);
        end
        st_next[0].s = x;
        // log2 square-and-compare steps; mantissa stays in [2^31, 2^32)
        for (int j = 0; j < LOG_STEPS; j++)
        begin
            st_next[S_LOG + j] = st_reg[S_LOG + j - 1];
            sq = {32'd0, st_reg[S_LOG + j - 1].m[31:0]} * {32'd0, st_reg[S_LOG + j - 1].m[31:0]};
            sq = sq >> 31;
            if (sq[63:32] != '0)
            begin
                st_next[S_LOG + j].m = sq >> 1;
                st_next[S_LOG + j].f[31 - j] = 1'b1;
            end
            else
                st_next[S_LOG + j].m = sq;
        end
        // scale to -2 ln p (tails) or r = x*x (center), partial products
        st_next[S_SCL] = st_reg[S_SCL - 1];
        if (st_reg[S_SCL - 1].region == incdf_pkg::REG_LOWER ||
            st_reg[S_SCL - 1].region == incdf_pkg::REG_UPPER)
        begin
            l2 = incdf_pkg::q32_t'((64'(PROB_BITS) - 64'(st_reg[S_SCL - 1].k)) << 32)
                 - incdf_pkg::q32_t'(st_reg[S_SCL - 1].f);
            st_next[S_SCL].pn = incdf_pkg::mul_parts(l2, incdf_pkg::TWO_LN2);
        end
        else
            st_next[S_SCL].pn = incdf_pkg::mul_parts(st_reg[S_SCL - 1].s,
                                                     st_reg[S_SCL - 1].s);
        // scale finish
        st_next[S_SCF] = st_reg[S_SCF - 1];
        l2 = incdf_pkg::mul_sum(st_reg[S_SCF - 1].pn);
        if (st_reg[S_SCF - 1].region == incdf_pkg::REG_LOWER ||
            st_reg[S_SCF - 1].region == incdf_pkg::REG_UPPER)
        begin
            st_next[S_SCF].m = l2[63] ? 64'd0 : 64'(l2);
            st_next[S_SCF].q = '0;
        end
        else
            st_next[S_SCF].q = l2;
        // square root bit steps (tails only): remainder = (m << 32) - q*q
        for (int b = 0; b < SQ_STEPS; b++)
        begin
            st_next[S_SQ + b] = st_reg[S_SQ + b - 1];
            if (st_reg[S_SQ + b - 1].region == incdf_pkg::REG_LOWER ||
                st_reg[S_SQ + b - 1].region == incdf_pkg::REG_UPPER)
            begin
                rem   = (b == 0) ? {32'd0, st_reg[S_SQ + b - 1].m, 32'd0}
                                 : st_reg[S_SQ + b - 1].dvd;
                trial = (128'(st_reg[S_SQ + b - 1].q) << (41 - b))
                        + (128'(1) << (2 * (40 - b)));
                if (rem >= trial)
                begin
                    rem = rem - trial;
                    st_next[S_SQ + b].q = st_reg[S_SQ + b - 1].q
                                          | incdf_pkg::q32_t'(64'(1) << (40 - b));
                end
                st_next[S_SQ + b].dvd = rem;
            end
        end
        // select coefficient start
        st_next[S_SEL] = st_reg[S_SEL - 1];
        if (st_reg[S_SEL - 1].region == incdf_pkg::REG_CENTER)
        begin
            st_next[S_SEL].acc_n = incdf_pkg::coef_a(0);
            st_next[S_SEL].acc_d = incdf_pkg::coef_b(0);
        end
        else
        begin
            st_next[S_SEL].acc_n = incdf_pkg::coef_c(0);
            st_next[S_SEL].acc_d = incdf_pkg::coef_d(0);
        end
        // Horner: partial products in one stage, sum and coefficient in the next
        for (int h = 0; h < HORN; h++)
        begin
            stg_t pa;
            stg_t pb;
            incdf_pkg::q32_t mn;
            incdf_pkg::q32_t md;
            pa = st_reg[S_H + 2 * h - 1];
            st_next[S_H + 2 * h] = pa;
            st_next[S_H + 2 * h].pn = incdf_pkg::mul_parts(pa.acc_n,
                (pa.region == incdf_pkg::REG_CENTER && h == HORN - 1) ? pa.s : pa.q);
            st_next[S_H + 2 * h].pd = incdf_pkg::mul_parts(pa.acc_d, pa.q);
            pb = st_reg[S_H + 2 * h];
            st_next[S_H + 2 * h + 1] = pb;
            mn = incdf_pkg::mul_sum(pb.pn);
            md = incdf_pkg::mul_sum(pb.pd);
            if (pb.region == incdf_pkg::REG_CENTER)
            begin
                if (h < 5)
                    st_next[S_H + 2 * h + 1].acc_n = mn + incdf_pkg::coef_a(h + 1);
                else
                    st_next[S_H + 2 * h + 1].acc_n = mn;
                if (h < 4)
                    st_next[S_H + 2 * h + 1].acc_d = md + incdf_pkg::coef_b(h + 1);
                else if (h == 4)
                    st_next[S_H + 2 * h + 1].acc_d = md + incdf_pkg::q32_t'(64'(1) << 32);
            end
            else
            begin
                if (h < 5)
                    st_next[S_H + 2 * h + 1].acc_n = mn + incdf_pkg::coef_c(h + 1);
                if (h < 3)
                    st_next[S_H + 2 * h + 1].acc_d = md + incdf_pkg::coef_d(h + 1);
                else if (h == 3)
                    st_next[S_H + 2 * h + 1].acc_d = md + incdf_pkg::q32_t'(64'(1) << 32);
            end
        end
        // divide setup: sign, magnitude, divisor floor, rounding half
        begin
            stg_t p;
            logic [63:0] n;
            logic [63:0] d;
            logic        ng;
            p = st_reg[S_PRE - 1];
            st_next[S_PRE] = p;
            ng = (p.region == incdf_pkg::REG_UPPER) ? !p.acc_n[63] : p.acc_n[63];
            n  = p.acc_n[63] ? 64'(-p.acc_n) : 64'(p.acc_n);
            if (p.acc_n == '0)
                ng = 1'b0;
            d  = (p.acc_d < 1) ? 64'd1 : 64'(p.acc_d);
            st_next[S_PRE].neg = ng;
            st_next[S_PRE].dvs = d;
            st_next[S_PRE].dvd = (128'(n) << FRAC_BITS) + 128'(d >> 1);
            st_next[S_PRE].f   = '0;
            st_next[S_PRE].m   = '0;
            st_next[S_PRE].big = 1'b0;
        end
        // restoring divide; a high half at or above the divisor saturates,
        // otherwise the high half is itself the running remainder
        for (int v = 0; v < DIV_STEPS; v++)
        begin
            stg_t p;
            logic [64:0] r2;
            p  = st_reg[S_DIV + v - 1];
            st_next[S_DIV + v] = p;
            if (v == 0 && (p.dvd[127:64] >= p.dvs))
                st_next[S_DIV + v].big = 1'b1;
            r2 = (v == 0) ? {1'b0, p.dvd[127:64]} : {1'b0, p.f};
            r2 = {r2[63:0], p.dvd[63 - v]};
            if (r2 >= {1'b0, p.dvs})
            begin
                r2 = r2 - {1'b0, p.dvs};
                st_next[S_DIV + v].m[63 - v] = 1'b1;
            end
            st_next[S_DIV + v].f = r2[63:0];
        end
        // output saturation
        begin
            stg_t p;
            logic [63:0] lim;
            logic [63:0] qo;
            p = st_reg[NSTG - 2];
            st_next[NSTG - 1] = p;
            lim = p.neg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            qo  = (p.big || p.m > lim) ? lim : p.m;
            qo  = p.neg ? 64'(-qo) : qo;
            if (p.region == incdf_pkg::REG_ZERO)
                qo = 64'h8000_0000;
            st_next[NSTG - 1].m = qo;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            vld_reg <= '0;
        else if (adv)
            vld_reg <= {vld_reg[NSTG-2:0], s_axis_tvalid};
    end

    always_ff @(posedge clk)
    begin
        if (adv)
            for (int i = 0; i < NSTG; i++)
                st_reg[i] <= st_next[i];
    end

    `INCDF_ASSERT(a_ready_adv, s_axis_tready == (!m_axis_tvalid || m_axis_tready),
        "ready must follow output stall")
    `INCDF_ASSERT_NEXT(a_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid,
        "pending result dropped")
    `INCDF_ASSERT_NEXT(a_hold_data, m_axis_tvalid && !m_axis_tready,
        $stable(m_axis_tdata), "pending result changed")

endmodule
